[sv/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, constants and round functions for the hasher modules.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Datapath command from the controller.
   typedef struct packed {
      logic       load_byte;   // write byte into block at fill position
      logic [7:0] byte_val;    // byte to write
      logic       start_blk;   // copy hash into working vars, clear round count
      logic       do_round;    // perform one compression round
      logic       finish_blk;  // add working vars into hash words
      logic       init_hash;   // reload initial hash values
      logic       clear_fill;  // reset fill and bit count
      logic       count_byte;  // add eight bits to the message length
   } dp_cmd_type;

   // Datapath status to the controller.
   typedef struct packed {
      logic [5:0]  fill;
      logic [63:0] bit_count;
      logic        round_last;
   } dp_sts_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[i];
   endfunction

   function automatic logic [31:0] init_h(input logic [2:0] i);
      logic [31:0] h [8];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[i];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

[sv/sha256_dp.sv]
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Rolling 16-word message schedule that also collects the block bytes,
// working variables and hash words. One compression round per cycle.
// ----------------------------------------------------------------------------
module sha256_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  sha256_pkg::dp_cmd_type cmd,
   output sha256_pkg::dp_sts_type sts,
   output logic [31:0]            hash_word [8]
);
   import sha256_pkg::*;

   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] h_ff [8];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  rnd_ff;
   logic [31:0] w_cur, w_new, s0, s1, t1, t2, big0, big1, ch, maj;

   // Fill position and bit length.
   always_comb begin
      fill_in = fill_ff;
      bits_in = bits_ff;
      if (cmd.load_byte) fill_in = fill_ff + 6'd1;
      if (cmd.count_byte) bits_in = bits_ff + 64'd8;
      if (cmd.clear_fill) begin
         fill_in = '0;
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bits_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         bits_ff <= bits_in;
      end
   end

   // Schedule word for this round and the next expanded word.
   always_comb begin
      s0    = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1    = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
      w_cur = w_ff[0];
      big1  = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1    = v_ff[7] + big1 + ch + round_k(rnd_ff) + w_cur;
      big0  = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2    = big0 + maj;
   end

   // Schedule window, working variables and round counter. Between
   // compressions the window collects the block bytes, big-endian per word.
   always_ff @(posedge clock) begin
      if (cmd.start_blk) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
         rnd_ff <= '0;
      end else if (cmd.do_round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         rnd_ff  <= rnd_ff + 6'd1;
      end else if (cmd.load_byte) begin
         w_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b111} -: 8] <= cmd.byte_val;
      end
   end

   // Hash words.
   always_ff @(posedge clock) begin
      if (reset || cmd.init_hash) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= init_h(3'(i));
      end else if (cmd.finish_blk) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end
   end

   assign sts.fill       = fill_ff;
   assign sts.bit_count  = bits_ff;
   assign sts.round_last = (rnd_ff == 6'd63);
   assign hash_word      = h_ff;

endmodule

[sv/sha256_ctrl.sv]
// ----------------------------------------------------------------------------
// SHA-256 controller
// Accepts beats, sequences padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             in_byte,
   input  logic                   in_has,
   input  logic                   in_end,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   out_ready,
   output logic                   out_valid,
   output logic [2:0]             out_index,
   input  sha256_pkg::dp_sts_type sts,
   output sha256_pkg::dp_cmd_type cmd
);
   import sha256_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_START = 7'b0000010,
      ST_ROUND = 7'b0000100,
      ST_ADD   = 7'b0001000,
      ST_PAD   = 7'b0010000,
      ST_EMIT  = 7'b0100000,
      ST_INIT  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic        closing_ff, closing_in;  // message end pending
   logic        padded_ff, padded_in;    // 0x80 already placed
   logic        len_blk_ff, len_blk_in;  // length goes in the current block
   logic [63:0] len_ff, len_in;          // length latched at close
   logic [2:0]  idx_ff, idx_in;
   logic        acc;

   assign in_ready  = (state_ff == ST_IDLE);
   assign acc       = in_valid && in_ready;
   assign out_valid = (state_ff == ST_EMIT);
   assign out_index = idx_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      closing_in = closing_ff;
      padded_in  = padded_ff;
      len_blk_in = len_blk_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               cmd.load_byte  = in_has;
               cmd.count_byte = in_has;
               cmd.byte_val   = in_byte;
               closing_in     = in_end;
               padded_in      = 1'b0;
               len_blk_in     = 1'b0;
               len_in         = sts.bit_count + (in_has ? 64'd8 : 64'd0);
               if (in_has && sts.fill == 6'd63) state_in = ST_START;
               else if (in_end) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            // One padding byte per cycle: marker, zeros, then length. The
            // length fits behind the marker only if the marker lands below
            // byte 56; otherwise it goes in one more block.
            cmd.load_byte = 1'b1;
            if (!padded_ff) begin
               cmd.byte_val = PAD_BYTE;
               padded_in    = 1'b1;
               len_blk_in   = (sts.fill < 6'd56);
            end else if (len_blk_ff && sts.fill >= 6'd56) begin
               cmd.byte_val = len_ff[{~sts.fill[2:0], 3'b111} -: 8];
            end else begin
               cmd.byte_val = 8'h00;
            end
            if (sts.fill == 6'd63) state_in = ST_START;
         end
         ST_START: begin
            cmd.start_blk = 1'b1;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            if (sts.round_last) state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.finish_blk = 1'b1;
            if (!closing_ff) state_in = ST_IDLE;
            else if (padded_ff && len_blk_ff) begin
               state_in = ST_EMIT;
               idx_in   = '0;
            end else begin
               // The next block carries the length once the marker is out.
               len_blk_in = padded_ff;
               state_in   = ST_PAD;
            end
         end
         ST_EMIT: begin
            if (out_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init_hash  = 1'b1;
            cmd.clear_fill = 1'b1;
            closing_in     = 1'b0;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         closing_ff <= 1'b0;
         padded_ff  <= 1'b0;
         len_blk_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         closing_ff <= closing_in;
         padded_ff  <= padded_in;
         len_blk_ff <= len_blk_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
   end

endmodule

[sv/sha256_stream_hasher_unit.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream with SHA-256 and emits the digest as eight words.
// ----------------------------------------------------------------------------
// Usage:
// The request channel takes one beat per cycle while the block collects
// bytes: tdata carries the message byte, tuser[0] says whether the byte is
// valid and tlast closes the message. Each 64th byte starts a compression
// (load, 64 rounds from the single shared round unit, hash add), during
// which req_tready is low. A closing beat costs padding at one byte per
// cycle up to the block end plus one or two compressions, then the digest
// leaves on the response channel as eight beats, word 0 first, with
// word_index in tuser and tlast on the eighth word. A stalled receiver
// holds the current word; no new request is taken until the digest is out
// and the hash state is reinitialized. Reset returns the block to the
// initial hash values with an empty message.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // has_byte
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [2:0]  rsp_tuser,   // word_index
   output logic        rsp_tlast    // last_word
);
   import sha256_pkg::*;

   dp_cmd_type  cmd;
   dp_sts_type  sts;
   logic [31:0] hash_word [8];
   logic [2:0]  idx;

   sha256_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_byte   (req_tdata),
      .in_has    (req_tuser),
      .in_end    (req_tlast),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_index (idx),
      .sts       (sts),
      .cmd       (cmd)
   );

   sha256_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .hash_word (hash_word)
   );

   assign rsp_tdata = hash_word[idx];
   assign rsp_tuser = idx;
   assign rsp_tlast = (idx == 3'd7);

   // No request is taken while the digest is being delivered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted during digest output");

   // Words leave in order.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid &&
      rsp_tuser == $past(rsp_tuser) + 3'd1))
      else $error("digest word order broken");

   // The block buffer is empty right after a digest completes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> ##1 (sts.fill == 6'd0))
      else $error("fill not cleared after digest");

endmodule
